### src/ilc_pkg.sv
// Package for the inverse logistic curve evaluator: widths, pipeline depths,
// register indexes, fixed-point constants and the sideband types.
// No dependencies.
package ilc_pkg;

   localparam int FRAC_BITS = 8;
   localparam int VAL_W     = 16;
   localparam int IDX_W     = 3;

   // Register indexes of the configuration port.
   typedef enum logic [IDX_W-1:0] {
      REG_MIDPOINT      = 3'd0,
      REG_SPREAD        = 3'd1,
      REG_PEAK          = 3'd2,
      REG_LENGTH_MODE   = 3'd3,
      REG_KEEP_ZERO_AGE = 3'd4
   } reg_index_type;

   localparam logic [VAL_W-1:0] ONE_FIX = VAL_W'(1 << FRAC_BITS);

   // Pipeline shape: entry stage, t divider, u stages, 2^f stages,
   // denominator stages, result divider.
   localparam int TQ_W       = 19;
   localparam int DIV1_END   = TQ_W;
   localparam int U_STAGES   = 2;
   localparam int EXP_STAGES = 9;
   localparam int DEN_STAGES = 2;
   localparam int QV_W       = VAL_W;
   localparam int PIPE_DEPTH = 1 + TQ_W + U_STAGES + EXP_STAGES + DEN_STAGES + QV_W;

   localparam int DEN_W = 53;
   localparam int M_W   = 31;

   localparam logic [18:0] LOG2_19_Q16 = 19'd278392;
   localparam logic [29:0] LN2_Q30     = 30'd744261118;
   localparam logic [30:0] ONE_Q30     = 31'd1073741824;
   // floor(v/6) for v below 2^18 as (v * RECIP6) >> 20.
   localparam logic [17:0] RECIP6      = 18'd174763;

   localparam logic [30:0] ROOT_TAB [4] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436
   };

   typedef struct packed {
      logic             valid;
      logic             ovr;
      logic [VAL_W-1:0] ovr_val;
   } side_type;

   typedef struct packed {
      logic [5:0] nraw;
      logic [3:0] fh;
   } expo_type;

endpackage

### src/inverse_logistic_curve.sv
// Top level of the inverse logistic curve evaluator, one fully pipelined datapath.
// Depends on ilc_pkg.
//
// Usage: a position is transferred at a rising edge where start is high and
// busy is low. busy is high only in the cycle after reset; otherwise a new
// position may be started in every cycle. Each result appears on rsp_value
// with rsp_strobe high for exactly one cycle, and results leave in start order.
// Throughput is one item per cycle while busy is low; the pipeline holds the entry
// stage, the two restoring dividers (19 stages for t, 16 stages for the final quotient),
// the u stages, the multiplier stages of the 2^f evaluation and the denominator stages.
// The receiver cannot stall, so the pipeline advances on every clock.
// Configuration is written through csr_write, csr_index and csr_data and takes effect
// at once; change it only while no item is in flight, which the block does not enforce.
// Synchronous reset empties the pipeline and loads midpoint 0, spread 1.0,
// peak 1.0, age mode and zero-age suppression.
module inverse_logistic_curve (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [ilc_pkg::VAL_W-1:0] req_position,
   output logic                      rsp_strobe,
   output logic [ilc_pkg::VAL_W-1:0] rsp_value,
   input  logic                      csr_write,
   input  logic [ilc_pkg::IDX_W-1:0] csr_index,
   input  logic [ilc_pkg::VAL_W-1:0] csr_data
);

   localparam int P1 = ilc_pkg::DIV1_END + 1;       // u product stage
   localparam int DV = ilc_pkg::QV_W;

   logic [15:0] midpoint_ff, spread_ff, peak_ff;
   logic        length_mode_ff, keep_zero_ff;
   logic        busy_ff;
   logic        rsp_strobe_ff;
   logic [15:0] rsp_value_ff;

   ilc_pkg::side_type side_ff [ilc_pkg::PIPE_DEPTH];
   ilc_pkg::side_type side_in;

   // Entry stage logic.
   logic signed [16:0] d_in;
   logic [15:0]        mag_in;
   logic [18:0]        lim_in;
   logic               accept;

   // t divider.
   logic [15:0] rem1_ff [ilc_pkg::DIV1_END+1];
   logic [18:0] nb1_ff  [ilc_pkg::DIV1_END+1];
   logic [18:0] q1_ff   [ilc_pkg::DIV1_END+1];
   logic        pos1_ff [ilc_pkg::DIV1_END+1];

   logic [37:0] prod_ff;
   logic        posu_ff;
   logic [37:0] rnd;
   logic [20:0] umag;
   logic [21:0] uu;
   logic [15:0] f_ff;
   logic [5:0]  nraw_ff;

   ilc_pkg::expo_type ex_ff [ilc_pkg::EXP_STAGES];
   logic [41:0] ly_prod;
   logic [51:0] y2_prod;
   logic [47:0] y3_prod;
   logic [35:0] y3d_prod;
   logic [25:0] y_e1_ff, y_e2_ff, y_e3_ff, y_e4_ff;
   logic [21:0] y2_e2_ff, y2_e3_ff, y2_e4_ff;
   logic [17:0] y3_e3_ff;
   logic [15:0] y3d_e4_ff;
   logic [30:0] m_ff [5];
   logic [61:0] rprod [4];

   logic [ilc_pkg::DEN_W-1:0] shifted, den_ff;
   logic [ilc_pkg::DEN_W-1:0] num_in;

   // Result divider.
   logic [ilc_pkg::DEN_W-1:0] rem2_ff [DV+1];
   logic [ilc_pkg::DEN_W-1:0] den2_ff [DV+1];
   logic [15:0]               nb2_ff  [DV+1];
   logic [15:0]               q2_ff   [DV+1];

   assign accept = start && !busy_ff;

   always_comb begin
      d_in   = $signed({1'b0, midpoint_ff}) - $signed({1'b0, req_position});
      mag_in = d_in[16] ? 16'(-d_in) : d_in[15:0];
      lim_in = 19'(spread_ff) * 19'd5;
      side_in.valid   = accept;
      side_in.ovr     = 1'b1;
      side_in.ovr_val = '0;
      priority if (!length_mode_ff && !keep_zero_ff && req_position == '0) begin
         side_in.ovr_val = '0;
      end else if (!d_in[16] && 19'(mag_in) > lim_in) begin
         side_in.ovr_val = peak_ff;
      end else if (d_in[16] && 19'(mag_in) > lim_in) begin
         side_in.ovr_val = '0;
      end else begin
         side_in.ovr = 1'b0;
      end
   end

   // Rounded |u| and biased u; the bias of 32 keeps the integer part positive.
   always_comb begin
      rnd  = prod_ff + 38'd32768;
      umag = rnd[36:16];
      uu   = posu_ff ? (22'h200000 - 22'(umag)) : (22'h200000 + 22'(umag));
   end

   always_comb begin
      ly_prod  = 42'(f_ff[11:0]) * 42'(ilc_pkg::LN2_Q30);
      y2_prod  = 52'(y_e1_ff) * 52'(y_e1_ff);
      y3_prod  = 48'(y2_e2_ff) * 48'(y_e2_ff);
      y3d_prod = 36'(y3_e3_ff) * 36'(ilc_pkg::RECIP6);
      for (int i = 0; i < 4; i++) begin
         rprod[i] = 62'(m_ff[i]) * 62'(ilc_pkg::ROOT_TAB[i]);
      end
   end

   always_comb begin
      if (ex_ff[8].nraw >= 6'd32) begin
         shifted = ilc_pkg::DEN_W'(m_ff[4]) << 5'(ex_ff[8].nraw - 6'd32);
      end else begin
         shifted = ilc_pkg::DEN_W'(m_ff[4]) >> 6'(6'd32 - ex_ff[8].nraw);
      end
      num_in = (ilc_pkg::DEN_W'(peak_ff) << 30) + (den_ff >> 1);
   end

   // Control, configuration and the sideband that travels with each item.
   always_ff @(posedge clock) begin
      side_ff[0].ovr     <= side_in.ovr;
      side_ff[0].ovr_val <= side_in.ovr_val;
      for (int i = 1; i < ilc_pkg::PIPE_DEPTH; i++) begin
         side_ff[i].ovr     <= side_ff[i-1].ovr;
         side_ff[i].ovr_val <= side_ff[i-1].ovr_val;
      end
      if (reset) begin
         midpoint_ff    <= '0;
         spread_ff      <= ilc_pkg::ONE_FIX;
         peak_ff        <= ilc_pkg::ONE_FIX;
         length_mode_ff <= 1'b0;
         keep_zero_ff   <= 1'b0;
         busy_ff        <= 1'b1;
         rsp_strobe_ff  <= 1'b0;
         for (int i = 0; i < ilc_pkg::PIPE_DEPTH; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else begin
         busy_ff          <= 1'b0;
         side_ff[0].valid <= side_in.valid;
         for (int i = 1; i < ilc_pkg::PIPE_DEPTH; i++) begin
            side_ff[i].valid <= side_ff[i-1].valid;
         end
         rsp_strobe_ff <= side_ff[ilc_pkg::PIPE_DEPTH-1].valid;
         if (csr_write) begin
            unique case (csr_index)
               ilc_pkg::REG_MIDPOINT:      midpoint_ff    <= csr_data;
               ilc_pkg::REG_SPREAD:        spread_ff      <= csr_data;
               ilc_pkg::REG_PEAK:          peak_ff        <= csr_data;
               ilc_pkg::REG_LENGTH_MODE:   length_mode_ff <= csr_data[0];
               ilc_pkg::REG_KEEP_ZERO_AGE: keep_zero_ff   <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      // The quotient of t stays below 2^19, so the top dividend bits start as remainder.
      rem1_ff[0] <= 16'(mag_in[15:3]);
      nb1_ff[0]  <= {mag_in[2:0], 16'b0};
      q1_ff[0]   <= '0;
      pos1_ff[0] <= !d_in[16] && (d_in != '0);
      for (int i = 1; i <= ilc_pkg::DIV1_END; i++) begin
         logic [16:0] trial;
         logic        ge;
         trial = {rem1_ff[i-1], nb1_ff[i-1][18]};
         ge    = trial >= {1'b0, spread_ff};
         rem1_ff[i] <= ge ? 16'(trial - {1'b0, spread_ff}) : trial[15:0];
         nb1_ff[i]  <= nb1_ff[i-1] << 1;
         q1_ff[i]   <= {q1_ff[i-1][17:0], ge};
         pos1_ff[i] <= pos1_ff[i-1];
      end

      // A zero spread only reaches here with zero distance, where t is zero.
      prod_ff <= 38'(spread_ff == '0 ? 19'd0 : q1_ff[ilc_pkg::DIV1_END])
                 * 38'(ilc_pkg::LOG2_19_Q16);
      posu_ff <= pos1_ff[ilc_pkg::DIV1_END];

      nraw_ff <= uu[21:16];
      f_ff    <= uu[15:0];

      ex_ff[0] <= '{nraw: nraw_ff, fh: f_ff[15:12]};
      for (int i = 1; i < ilc_pkg::EXP_STAGES; i++) begin
         ex_ff[i] <= ex_ff[i-1];
      end
      y_e1_ff   <= ly_prod[41:16];
      y_e2_ff   <= y_e1_ff;
      y2_e2_ff  <= y2_prod[51:30];
      y_e3_ff   <= y_e2_ff;
      y2_e3_ff  <= y2_e2_ff;
      y3_e3_ff  <= y3_prod[47:30];
      y_e4_ff   <= y_e3_ff;
      y2_e4_ff  <= y2_e3_ff;
      y3d_e4_ff <= y3d_prod[35:20];
      m_ff[0]   <= ilc_pkg::ONE_Q30 + 31'(y_e4_ff) + 31'(y2_e4_ff >> 1) + 31'(y3d_e4_ff);
      // Multiply in 2^(1/2), 2^(1/4), 2^(1/8), 2^(1/16) for the top fraction bits.
      for (int i = 0; i < 4; i++) begin
         m_ff[i+1] <= ex_ff[i+4].fh[3-i] ? rprod[i][60:30] : m_ff[i];
      end

      den_ff <= ilc_pkg::DEN_W'(ilc_pkg::ONE_Q30) + shifted;

      // The quotient is below 2^16, so the top 37 bits of the numerator start as remainder.
      rem2_ff[0] <= num_in >> 16;
      nb2_ff[0]  <= num_in[15:0];
      den2_ff[0] <= den_ff;
      q2_ff[0]   <= '0;
      for (int i = 1; i <= DV; i++) begin
         logic [ilc_pkg::DEN_W:0] trial2;
         logic                    ge2;
         trial2 = {rem2_ff[i-1], nb2_ff[i-1][15]};
         ge2    = trial2 >= {1'b0, den2_ff[i-1]};
         rem2_ff[i] <= ge2 ? ilc_pkg::DEN_W'(trial2 - {1'b0, den2_ff[i-1]})
                           : trial2[ilc_pkg::DEN_W-1:0];
         nb2_ff[i]  <= nb2_ff[i-1] << 1;
         den2_ff[i] <= den2_ff[i-1];
         q2_ff[i]   <= {q2_ff[i-1][14:0], ge2};
      end

      rsp_value_ff <= side_ff[ilc_pkg::PIPE_DEPTH-1].ovr ?
                      side_ff[ilc_pkg::PIPE_DEPTH-1].ovr_val : q2_ff[DV];
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;

   // P1 marks where the t quotient enters the u product; it equals the u stage index.
   if (P1 != ilc_pkg::DIV1_END + 1) begin : g_bad_shape
      $error("pipeline shape mismatch");
   end

endmodule

### src/ilc_checker.sv
// Port-level checker for the inverse logistic curve evaluator and its bind.
// Depends on ilc_pkg and on the top level inverse_logistic_curve.
module ilc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic [ilc_pkg::VAL_W-1:0] rsp_value
);

   localparam int LAT = ilc_pkg::PIPE_DEPTH + 1;

   // A start transfer always produces its result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result missing after start transfer");

   // No result appears that was not started the fixed latency earlier.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without start transfer");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> (busy && !rsp_strobe))
      else $error("busy low or strobe high after reset");

   a_value_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_value))
      else $error("unknown result value");

endmodule

bind inverse_logistic_curve ilc_checker u_ilc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_value  (rsp_value)
);

### sim/testbench.sv
// Self-checking testbench for the inverse logistic curve evaluator.
// Depends on ilc_pkg and inverse_logistic_curve; predicts each curve value
// in fixed point and compares it with the pipeline output in order.
`timescale 1ns / 100ps

module testbench;

   localparam int DRAIN_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ilc_pkg::VAL_W-1:0] req_position = '0;
   logic rsp_strobe;
   logic [ilc_pkg::VAL_W-1:0] rsp_value;
   logic csr_write = 1'b0;
   logic [ilc_pkg::IDX_W-1:0] csr_index = '0;
   logic [ilc_pkg::VAL_W-1:0] csr_data = '0;

   inverse_logistic_curve dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_position(req_position), .rsp_strobe(rsp_strobe), .rsp_value(rsp_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor copy of the registers.
   logic [15:0] mid_r, spr_r, peak_r;
   logic len_r, kza_r;

   logic [15:0] pending_positions[$];
   logic [15:0] expected_values[$];
   int errors = 0;
   int idle_cycles = 0;
   bit feeding_done = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic logic [63:0] pow2_fraction(input logic [15:0] f);
      logic [63:0] r, y, y2, y3, m;
      logic [63:0] roots[4];
      roots[0] = 64'd1518500250; roots[1] = 64'd1276901417;
      roots[2] = 64'd1170923762; roots[3] = 64'd1121280436;
      r = {52'd0, f[11:0]};
      y = (r * 64'd744261118) >> 16;
      y2 = (y * y) >> 30;
      y3 = (y2 * y) >> 30;
      m = 64'd1073741824 + y + y2 / 2 + y3 / 6;
      for (int i = 0; i < 4; i++)
         if (f[15-i]) m = (m * roots[i]) >> 30;
      return m;
   endfunction

   function automatic logic [15:0] curve_value(input logic [15:0] x);
      longint d, lim, u, n;
      logic [63:0] mag, tq, umag, uu, m, den, num, v;
      d = longint'(mid_r) - longint'(x);
      lim = 5 * longint'(spr_r);
      if (!len_r && !kza_r && x == 0) return 16'd0;
      if (d > lim) return peak_r;
      if (d < -lim) return 16'd0;
      mag = (d < 0) ? -d : d;
      tq = (spr_r == 0) ? 64'd0 : ((mag << 16) / spr_r);
      umag = (tq * 64'd278392 + 64'd32768) >> 16;
      u = (d > 0) ? -longint'(umag) : longint'(umag);
      uu = u + 64'd32 * 64'd65536;
      n = longint'(uu >> 16) - 32;
      m = pow2_fraction(uu[15:0]);
      if (n >= 0) den = 64'd1073741824 + (m << n);
      else den = 64'd1073741824 + (m >> (-n));
      num = ({48'd0, peak_r} << 30) + den / 2;
      v = num / den;
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   // Driver: random gaps between transfers, none while the queue is empty.
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_values.push_back(curve_value(req_position));
         if (pending_positions.size() > 0 && gap == 0 && $urandom_range(0, 3) != 0) begin
            req_position <= pending_positions.pop_front();
         end else begin
            start <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 40))
                                              : int'($urandom_range(0, 3));
         end
      end else if (!start) begin
         if (gap > 0) gap--;
         else if (pending_positions.size() > 0) begin
            req_position <= pending_positions.pop_front();
            start <= 1'b1;
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("unexpected value %0d", rsp_value));
            end else begin
               logic [15:0] want;
               want = expected_values.pop_front();
               if (want !== rsp_value)
                  report_mismatch($sformatf("value %0d, expected %0d", rsp_value, want));
            end
         end
         if (rsp_strobe || (start && !busy)) idle_cycles = 0;
         else if (!feeding_done) idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(input ilc_pkg::reg_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         ilc_pkg::REG_MIDPOINT: mid_r = data;
         ilc_pkg::REG_SPREAD: spr_r = data;
         ilc_pkg::REG_PEAK: peak_r = data;
         ilc_pkg::REG_LENGTH_MODE: len_r = data[0];
         default: kza_r = data[0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_positions.size() > 0 || start || expected_values.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_curve(input logic [15:0] mid, input logic [15:0] spr,
                            input logic [15:0] pk, input bit len, input bit kza);
      write_reg(ilc_pkg::REG_MIDPOINT, mid);
      write_reg(ilc_pkg::REG_SPREAD, spr);
      write_reg(ilc_pkg::REG_PEAK, pk);
      write_reg(ilc_pkg::REG_LENGTH_MODE, {15'd0, len});
      write_reg(ilc_pkg::REG_KEEP_ZERO_AGE, {15'd0, kza});
   endtask

   // Positions cluster around the midpoint so most land on the curved part.
   function automatic logic [15:0] near_midpoint();
      longint p;
      if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
      p = longint'(mid_r) + ($signed($urandom_range(0, 12 * spr_r)) - 6 * longint'(spr_r));
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      return p[15:0];
   endfunction

   initial begin
      mid_r = 16'd0; spr_r = 16'd256; peak_r = 16'd256; len_r = 1'b0; kza_r = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: defaults, extremes of position, zero age handling.
      pending_positions = '{16'd0, 16'd1, 16'd128, 16'd256, 16'd1280, 16'd1281,
                            16'hFFFF, 16'h8000, 16'h7FFF};
      wait_drained();
      set_curve(16'h0A00, 16'd256, 16'hFFFF, 1'b0, 1'b1);
      pending_positions = '{16'd0, 16'h0A00, 16'h0F00, 16'h0F01, 16'h0500, 16'h04FF,
                            16'h0A01, 16'h09FF, 16'hFFFF};
      wait_drained();
      // Zero spread and zero peak cases.
      set_curve(16'h1000, 16'd0, 16'd1, 1'b1, 1'b0);
      pending_positions = '{16'h1000, 16'h0FFF, 16'h1001, 16'd0};
      wait_drained();
      write_reg(ilc_pkg::REG_PEAK, 16'd0);
      pending_positions = '{16'h1000, 16'h0FFF, 16'd0};
      wait_drained();
      // Random phases through many settings, extremes included.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: set_curve(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
            1: set_curve(16'd0, 16'd1, 16'd1, 1'b0, 1'b0);
            default: set_curve(16'($urandom_range(0, 65535)),
                               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                           : 16'($urandom_range(1, 2048)),
                               16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
         endcase
         for (int k = 0; k < 100; k++) pending_positions.push_back(near_midpoint());
         wait_drained();
      end
      feeding_done = 1;
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
